// ===== rtl/core/csa_pkg.sv =====
// Package for the contiguous slot allocator: item types, status and mode
// codes, the sequencer state type and the slot map word geometry.
// Depends on nothing; every file of the block imports it.
package csa_pkg;

    // The slot map is held as words of WORD_BITS slots each.
    localparam int WORD_LOG      = 3;
    localparam int WORD_BITS     = 1 << WORD_LOG;
    localparam int DEFAULT_SLOTS = 256;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE        = 2'd0,
        STATUS_NO_RUN      = 2'd1,
        STATUS_FREE_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        mode_t      mode;
        logic [8:0] slot_count;
        logic [7:0] first_slot;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] granted_slot;
        logic [8:0] granted_count;
        logic [7:0] owner_heap;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SETUP,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/core/contiguous_slot_allocator_core.sv =====
// Contiguous slot allocator: first-fit allocation and release of runs of
// consecutive slots in a heap of SLOTS slots. Depends on csa_pkg.
//
// The free map lives in a single-port memory of ceil(SLOTS/8) words of eight
// slots, read with a registered output. After reset the block first sweeps
// that memory setting every slot free, one word a cycle, and takes no item
// until the sweep is over; the heap number register can be written at any
// time. One item is worked on at a time. An allocate streams the map through
// an eight-slot run counter at one word a cycle until the first fitting run
// ends; a granted run, and any accepted free, is then rewritten by
// read-modify-write of each map word it touches, a read state then a write
// state per word. A rejected request goes from idle straight to the response
// state. The result sits in an output register, so a new item is taken while
// the previous result still waits.
module contiguous_slot_allocator_core #(
    parameter int SLOTS = csa_pkg::DEFAULT_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  csa_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output csa_pkg::out_item_t out_item,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);
    import csa_pkg::*;

    localparam int ROWS   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW     = RIDX_W + WORD_LOG;          // slot index width
    localparam int EW     = SW + 1;                     // end index and run length
    localparam int WIDE_W = (EW > 10) ? EW : 10;        // request range checks

    // Free map memory: a set bit marks a free slot.
    logic [WORD_BITS-1:0] mem [ROWS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [RIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [RIDX_W-1:0]    mem_raddr;

    state_t            state_reg, state_next;
    logic [RIDX_W-1:0] row_reg, row_next;
    logic [RIDX_W-1:0] prow_reg, prow_next;
    logic              iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [EW-1:0]     run_reg, run_next;
    logic [SW-1:0]     lo_reg, lo_next;
    logic [EW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     end_reg, end_next;
    mode_t             mode_reg, mode_next;
    logic [8:0]        cnt_reg, cnt_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    logic [7:0]        heap_reg;

    // Scan of one word
    logic [EW-1:0]        run_v;
    logic                 found_v;
    logic [SW-1:0]        end_v;
    logic [SW-1:0]        idx_v;
    // Range mask of one word
    logic [WORD_BITS-1:0] mask_v;
    logic [EW-1:0]        sidx_v;
    // Request checks
    logic [WIDE_W-1:0]    req_cnt_w;
    logic [WIDE_W-1:0]    req_end_w;
    logic [EW-1:0]        hi_m1;
    logic [RIDX_W-1:0]    last_row;
    logic [EW-1:0]        start_w;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            prow_reg      <= '0;
            iss_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            heap_reg      <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            prow_reg      <= prow_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                heap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        end_reg      <= end_next;
        mode_reg     <= mode_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    // Run counter over the word read last cycle. The first slot at which the
    // run reaches the requested length ends the first-fit run.
    always_comb
    begin
        run_v   = run_reg;
        found_v = 1'b0;
        end_v   = '0;
        idx_v   = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            idx_v = {prow_reg, WORD_LOG'(b)};
            if (rdata_reg[b] && (EW'(idx_v) < EW'(SLOTS)))
            begin
                run_v = run_v + EW'(1);
                if (!found_v && (WIDE_W'(run_v) == WIDE_W'(cnt_reg)))
                begin
                    found_v = 1'b1;
                    end_v   = idx_v;
                end
            end
            else
            begin
                run_v = '0;
            end
        end
    end

    always_comb
    begin
        sidx_v = '0;
        mask_v = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            sidx_v    = EW'({row_reg, WORD_LOG'(b)});
            mask_v[b] = (sidx_v >= EW'(lo_reg)) && (sidx_v < hi_reg);
        end
    end

    assign req_cnt_w = WIDE_W'(in_item.slot_count);
    assign req_end_w = WIDE_W'(in_item.first_slot) + req_cnt_w;
    assign hi_m1     = hi_reg - EW'(1);
    assign last_row  = hi_m1[SW-1:WORD_LOG];
    assign start_w   = EW'(end_reg) + EW'(1) - EW'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        prow_next      = prow_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        end_next       = end_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = row_reg;
        mem_wdata      = '1;
        mem_raddr      = row_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (row_reg == RIDX_W'(ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = row_reg + RIDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = in_item.mode;
                    cnt_next  = in_item.slot_count;
                    res_next  = '{status: STATUS_DONE, granted_slot: 8'd0,
                                  granted_count: 9'd0, owner_heap: 8'd0};
                    if (in_item.mode == MODE_ALLOC)
                    begin
                        if ((req_cnt_w == '0) || (req_cnt_w > WIDE_W'(SLOTS)))
                        begin
                            res_next.status = STATUS_NO_RUN;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            row_next   = '0;
                            iss_next   = 1'b1;
                            pend_next  = 1'b0;
                            run_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if ((req_cnt_w == '0) || (req_end_w > WIDE_W'(SLOTS)))
                        begin
                            res_next.status = STATUS_FREE_REJECT;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            lo_next    = SW'(in_item.first_slot);
                            hi_next    = EW'(req_end_w);
                            row_next   = RIDX_W'(in_item.first_slot >> WORD_LOG);
                            state_next = ST_MARK_RD;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one word ahead of the run counter.
                pend_next = iss_reg;
                prow_next = row_reg;
                if (iss_reg)
                begin
                    if (row_reg == RIDX_W'(ROWS - 1))
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        row_next = row_reg + RIDX_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    run_next = run_v;
                    if (found_v)
                    begin
                        end_next   = end_v;
                        state_next = ST_SETUP;
                    end
                    else if (prow_reg == RIDX_W'(ROWS - 1))
                    begin
                        res_next.status = STATUS_NO_RUN;
                        state_next      = ST_RESP;
                    end
                end
            end

            ST_SETUP:
            begin
                lo_next    = SW'(start_w);
                hi_next    = EW'(end_reg) + EW'(1);
                row_next   = start_w[SW-1:WORD_LOG];
                res_next   = '{status: STATUS_DONE, granted_slot: 8'(start_w),
                               granted_count: cnt_reg, owner_heap: heap_reg};
                state_next = ST_MARK_RD;
            end

            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                mem_we = 1'b1;
                if (mode_reg == MODE_ALLOC)
                begin
                    mem_wdata = rdata_reg & ~mask_v;
                end
                else
                begin
                    mem_wdata = rdata_reg | mask_v;
                end
                if (row_reg == last_row)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    row_next   = row_reg + RIDX_W'(1);
                    state_next = ST_MARK_RD;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
